// ----- hdl/fdwm_pkg.sv -----
// ----------------------------------------------------------------------------
// fdwm_pkg
// Shared types and constants of the FIR dry/wet mixer.
// ----------------------------------------------------------------------------
package fdwm_pkg;

   localparam int GAIN_W    = 16;            // coefficient and share register width
   localparam int MUL_W     = GAIN_W + 1;    // serial multiplier operand, signed
   localparam int MUL_CNT_W = $clog2(MUL_W);
   localparam int Q_SHIFT   = 15;            // Q1.15 fraction bits
   localparam int CSR_W     = 32;
   localparam int CSR_AW    = 4;

   localparam logic [GAIN_W:0]   Q_ONE          = 17'd32768;
   localparam logic [GAIN_W-1:0] EVEN_GAIN_RST  = 16'd3277;
   localparam logic [GAIN_W-1:0] ODD_GAIN_RST   = 16'd3277;
   localparam logic [GAIN_W-1:0] DRY_SHARE_RST  = 16'd16384;

   typedef enum logic [1:0] {
      REG_EVEN_GAIN = 2'd0,
      REG_ODD_GAIN  = 2'd1,
      REG_DRY_SHARE = 2'd2,
      REG_UNUSED    = 2'd3
   } reg_index_type;

   // control word from the sequencer to the serial multiplier
   typedef struct packed {
      logic load;    // take new operands
      logic clear;   // zero the accumulator on load
      logic step;    // process one multiplier bit
      logic last;    // sign bit of the multiplier: subtract
   } mac_ctrl_type;

endpackage

// ----- hdl/fir_dry_wet_mixer.sv -----
// ----------------------------------------------------------------------------
// fir_dry_wet_mixer
// FIR filter over a TAPS-sample window with alternating even/odd tap gains,
// blended with the dry sample and rounded and saturated to SAMPLE_BITS.
// ----------------------------------------------------------------------------
// One sample is processed at a time. After the transfer the sequencer walks
// the delay line and sums the even and odd positions, then forms four 17-bit
// products on a single bit-serial shift-add multiplier (even sum by even gain,
// odd sum by odd gain, dry sample by dry share, filtered value by wet share),
// each a load step followed by one step per multiplier bit, and finally rounds
// and saturates into the output register, waiting until that register is free.
// A finished result sits in the output register while the next sample is taken.
module fir_dry_wet_mixer #(
   parameter int TAPS        = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,   // in_sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,   // out_sample
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fdwm_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [fdwm_pkg::CSR_W-1:0]           csr_pwdata,
   output logic [fdwm_pkg::CSR_W-1:0]           csr_prdata,
   output logic                                 csr_pready
);

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SUM_W   = SAMPLE_BITS + $clog2(TAPS);
   localparam int FILT_W  = SUM_W + 2;
   localparam int ACC_W   = FILT_W + fdwm_pkg::MUL_W + 1;
   localparam int RES_W   = ACC_W - fdwm_pkg::Q_SHIFT;
   localparam int TAP_CW  = $clog2(TAPS);
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (fdwm_pkg::Q_SHIFT - 1);
   localparam logic [TAP_CW-1:0] TAP_LAST = TAP_CW'(TAPS - 1);
   localparam logic [fdwm_pkg::MUL_CNT_W-1:0] MUL_LAST =
      fdwm_pkg::MUL_CNT_W'(fdwm_pkg::MUL_W - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUM, ST_LOAD_E, ST_MUL_E, ST_LOAD_O, ST_MUL_O,
      ST_LOAD_D, ST_MUL_D, ST_LOAD_W, ST_MUL_W, ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [TAP_CW-1:0]                  tap_cnt_ff, tap_cnt_in;
   logic [fdwm_pkg::MUL_CNT_W-1:0]     mul_cnt_ff, mul_cnt_in;
   logic signed [FILT_W-1:0]           filt_ff, filt_in;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [SAMPLE_BITS-1:0]             rsp_sample_ff, rsp_sample_in;

   logic [fdwm_pkg::GAIN_W-1:0]        even_gain, odd_gain, dry_share;
   logic [fdwm_pkg::GAIN_W:0]          wet_share;
   logic signed [SUM_W-1:0]            even_sum, odd_sum;
   logic signed [SAMPLE_BITS-1:0]      current;
   logic                               accept, out_free, rotate;
   fdwm_pkg::mac_ctrl_type             mac_ctrl;
   logic signed [ACC_W-1:0]            mac_a, acc, acc_round;
   logic [fdwm_pkg::MUL_W-1:0]         mac_b;
   logic signed [RES_W-1:0]            res;
   logic                               sat_ok;
   logic [SAMPLE_BITS-1:0]             res_sat;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rotate     = (state_ff == ST_SUM);
   assign wet_share  = fdwm_pkg::Q_ONE - {1'b0, dry_share};

   fdwm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .even_gain (even_gain),
      .odd_gain  (odd_gain),
      .dry_share (dry_share)
   );

   fdwm_window #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_in  (accept),
      .sample_in (req_tdata[SAMPLE_BITS-1:0]),
      .rotate    (rotate),
      .tap_odd   (tap_cnt_ff[0]),
      .even_sum  (even_sum),
      .odd_sum   (odd_sum),
      .current   (current)
   );

   // operand select for the shared multiplier
   always_comb begin
      mac_ctrl.load  = 1'b0;
      mac_ctrl.clear = 1'b0;
      mac_ctrl.step  = 1'b0;
      mac_ctrl.last  = (mul_cnt_ff == MUL_LAST);
      mac_a          = ACC_W'(even_sum);
      mac_b          = fdwm_pkg::MUL_W'(signed'(even_gain));
      unique case (state_ff)
         ST_LOAD_E: begin
            mac_ctrl.load  = 1'b1;
            mac_ctrl.clear = 1'b1;
         end
         ST_LOAD_O: begin
            mac_ctrl.load = 1'b1;
            mac_a         = ACC_W'(odd_sum);
            mac_b         = fdwm_pkg::MUL_W'(signed'(odd_gain));
         end
         ST_LOAD_D: begin
            mac_ctrl.load  = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_a          = ACC_W'(current);
            mac_b          = fdwm_pkg::MUL_W'(dry_share);
         end
         ST_LOAD_W: begin
            mac_ctrl.load = 1'b1;
            mac_a         = ACC_W'(filt_ff);
            mac_b         = wet_share;
         end
         ST_MUL_E, ST_MUL_O, ST_MUL_D, ST_MUL_W: begin
            mac_ctrl.step = 1'b1;
         end
         default: ;
      endcase
   end

   fdwm_serial_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .mul_a (mac_a),
      .mul_b (mac_b),
      .acc   (acc)
   );

   // round half up, then saturate to the sample range
   assign acc_round = (acc + HALF) >>> fdwm_pkg::Q_SHIFT;
   assign res       = acc_round[RES_W-1:0];
   assign sat_ok    = (&res[RES_W-1:SAMPLE_BITS-1]) || !(|res[RES_W-1:SAMPLE_BITS-1]);

   always_comb begin
      if (sat_ok) begin
         res_sat = res[SAMPLE_BITS-1:0];
      end else if (res[RES_W-1]) begin
         res_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         res_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_comb begin
      state_in      = state_ff;
      tap_cnt_in    = tap_cnt_ff;
      mul_cnt_in    = mul_cnt_ff;
      filt_in       = filt_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tap_cnt_in = '0;
               state_in   = ST_SUM;
            end
         end
         ST_SUM: begin
            tap_cnt_in = tap_cnt_ff + 1'b1;
            if (tap_cnt_ff == TAP_LAST) begin
               state_in = ST_LOAD_E;
            end
         end
         ST_LOAD_E, ST_LOAD_O, ST_LOAD_W: begin
            mul_cnt_in = '0;
            state_in   = state_type'(state_ff + 1'b1);
         end
         ST_LOAD_D: begin
            // capture the filtered value before the accumulator is reused
            mul_cnt_in = '0;
            filt_in    = acc_round[FILT_W-1:0];
            state_in   = ST_MUL_D;
         end
         ST_MUL_E, ST_MUL_O, ST_MUL_D, ST_MUL_W: begin
            mul_cnt_in = mul_cnt_ff + 1'b1;
            if (mul_cnt_ff == MUL_LAST) begin
               state_in = state_type'(state_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_sample_in = res_sat;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_cnt_ff    <= '0;
         mul_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tap_cnt_ff    <= tap_cnt_in;
         mul_cnt_ff    <= mul_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      filt_ff       <= filt_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_sample_ff);
   assign csr_pready = 1'b1;

   a_accept_starts_sum: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SUM))
      else $error("accepted sample did not start the window walk");

   a_tap_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (tap_cnt_ff <= TAP_LAST))
      else $error("tap counter past the window");

   a_mul_cnt_range: assert property (@(posedge clock) disable iff (reset)
      mac_ctrl.step |-> (mul_cnt_ff <= MUL_LAST))
      else $error("multiplier counter past the operand width");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && out_free) |=> (rsp_tvalid_ff && (state_ff == ST_IDLE)))
      else $error("finished result not loaded into the output register");

endmodule

// ----- hdl/fdwm_csr.sv -----
// ----------------------------------------------------------------------------
// fdwm_csr
// APB register file: even and odd tap gains and the dry share.
// ----------------------------------------------------------------------------
module fdwm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fdwm_pkg::CSR_AW-1:0]      paddr,
   input  logic [fdwm_pkg::CSR_W-1:0]       pwdata,
   output logic [fdwm_pkg::CSR_W-1:0]       prdata,
   output logic [fdwm_pkg::GAIN_W-1:0]      even_gain,
   output logic [fdwm_pkg::GAIN_W-1:0]      odd_gain,
   output logic [fdwm_pkg::GAIN_W-1:0]      dry_share
);

   logic [fdwm_pkg::GAIN_W-1:0] even_gain_ff, even_gain_in;
   logic [fdwm_pkg::GAIN_W-1:0] odd_gain_ff,  odd_gain_in;
   logic [fdwm_pkg::GAIN_W-1:0] dry_share_ff, dry_share_in;
   logic [fdwm_pkg::GAIN_W-1:0] wdata;
   logic                        wr_en;
   fdwm_pkg::reg_index_type     index;

   assign index = fdwm_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en = psel && penable && pwrite;
   assign wdata = pwdata[fdwm_pkg::GAIN_W-1:0];

   always_comb begin
      even_gain_in = even_gain_ff;
      odd_gain_in  = odd_gain_ff;
      dry_share_in = dry_share_ff;
      if (wr_en) begin
         unique case (index)
            fdwm_pkg::REG_EVEN_GAIN: even_gain_in = wdata;
            fdwm_pkg::REG_ODD_GAIN:  odd_gain_in  = wdata;
            fdwm_pkg::REG_DRY_SHARE: begin
               // clamp shares above one to dry only
               if ({1'b0, wdata} > fdwm_pkg::Q_ONE) begin
                  dry_share_in = fdwm_pkg::GAIN_W'(fdwm_pkg::Q_ONE);
               end else begin
                  dry_share_in = wdata;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         even_gain_ff <= fdwm_pkg::EVEN_GAIN_RST;
         odd_gain_ff  <= fdwm_pkg::ODD_GAIN_RST;
         dry_share_ff <= fdwm_pkg::DRY_SHARE_RST;
      end else begin
         even_gain_ff <= even_gain_in;
         odd_gain_ff  <= odd_gain_in;
         dry_share_ff <= dry_share_in;
      end
   end

   always_comb begin
      unique case (index)
         fdwm_pkg::REG_EVEN_GAIN: prdata = fdwm_pkg::CSR_W'(even_gain_ff);
         fdwm_pkg::REG_ODD_GAIN:  prdata = fdwm_pkg::CSR_W'(odd_gain_ff);
         fdwm_pkg::REG_DRY_SHARE: prdata = fdwm_pkg::CSR_W'(dry_share_ff);
         default:                 prdata = '0;
      endcase
   end

   assign even_gain = even_gain_ff;
   assign odd_gain  = odd_gain_ff;
   assign dry_share = dry_share_ff;

endmodule

// ----- hdl/fdwm_window.sv -----
// ----------------------------------------------------------------------------
// fdwm_window
// Sample delay line with a rotating read tap that sums even and odd
// window positions one sample per cycle while rotate is asserted.
// ----------------------------------------------------------------------------
module fdwm_window #(
   parameter int TAPS        = 10,
   parameter int SAMPLE_BITS = 16,
   parameter int SUM_W       = SAMPLE_BITS + $clog2(TAPS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_in,
   input  logic [SAMPLE_BITS-1:0]        sample_in,
   input  logic                          rotate,
   input  logic                          tap_odd,
   output logic signed [SUM_W-1:0]       even_sum,
   output logic signed [SUM_W-1:0]       odd_sum,
   output logic signed [SAMPLE_BITS-1:0] current
);

   logic [SAMPLE_BITS-1:0] win_ff [TAPS];
   logic [SAMPLE_BITS-1:0] win_in [TAPS];
   logic signed [SUM_W-1:0] even_ff, even_in;
   logic signed [SUM_W-1:0] odd_ff,  odd_in;
   logic signed [SUM_W-1:0] head;

   assign head = SUM_W'(signed'(win_ff[0]));

   always_comb begin
      win_in  = win_ff;
      even_in = even_ff;
      odd_in  = odd_ff;
      if (shift_in) begin
         // drop the oldest sample, append the new one
         for (int j = 0; j < TAPS - 1; j++) begin
            win_in[j] = win_ff[j+1];
         end
         win_in[TAPS-1] = sample_in;
         even_in = '0;
         odd_in  = '0;
      end else if (rotate) begin
         for (int j = 0; j < TAPS - 1; j++) begin
            win_in[j] = win_ff[j+1];
         end
         win_in[TAPS-1] = win_ff[0];
         if (tap_odd) begin
            odd_in = odd_ff + head;
         end else begin
            even_in = even_ff + head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TAPS; j++) begin
            win_ff[j] <= '0;
         end
      end else begin
         win_ff <= win_in;
      end
      even_ff <= even_in;
      odd_ff  <= odd_in;
   end

   assign even_sum = even_ff;
   assign odd_sum  = odd_ff;
   assign current  = signed'(win_ff[TAPS-1]);

endmodule

// ----- hdl/fdwm_serial_mac.sv -----
// ----------------------------------------------------------------------------
// fdwm_serial_mac
// Bit-serial shift-add multiply-accumulate: one multiplier bit per cycle while
// step is asserted, least significant first, two's complement sign bit subtracted.
// ----------------------------------------------------------------------------
module fdwm_serial_mac #(
   parameter int ACC_W = 40
) (
   input  logic                              clock,
   input  fdwm_pkg::mac_ctrl_type            ctrl,
   input  logic signed [ACC_W-1:0]           mul_a,
   input  logic [fdwm_pkg::MUL_W-1:0]        mul_b,
   output logic signed [ACC_W-1:0]           acc
);

   logic signed [ACC_W-1:0]    a_ff, a_in;
   logic [fdwm_pkg::MUL_W-1:0] b_ff, b_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    addend;

   assign addend = b_ff[0] ? a_ff : '0;

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      if (ctrl.load) begin
         a_in = mul_a;
         b_in = mul_b;
         if (ctrl.clear) begin
            acc_in = '0;
         end
      end else if (ctrl.step) begin
         acc_in = ctrl.last ? (acc_ff - addend) : (acc_ff + addend);
         a_in   = a_ff <<< 1;
         b_in   = b_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fir_dry_wet_mixer. A short directed table covers
// reset state, sample extremes, the dry-only clamp, an ignored register
// index and wet-only saturation. Random phases follow, each with its own
// gain and share setting and one of four idle patterns. Every result transfer
// is checked against a given table value, else a local bit-true model.
// ----------------------------------------------------------------------------
module testbench;

   localparam int TAPS         = 10;
   localparam int SAMPLE_W     = 16;
   localparam int HIST_LEN     = TAPS - 1;
   localparam int DATA_W       = ((SAMPLE_W + 7) / 8) * 8;
   localparam int LATENCY      = TAPS + 73;
   localparam int SETTLE       = 2 * LATENCY;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 250;
   localparam int HOLD_CYCLES  = 600;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef enum logic [0:0] {
      ROW_SAMPLE = 1'b0,
      ROW_WRITE  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type                 kind;
      fdwm_pkg::reg_index_type      reg_idx;
      logic [fdwm_pkg::CSR_W-1:0]   wdata;
      logic [SAMPLE_W-1:0]          sample;
      logic                         known;
      logic [SAMPLE_W-1:0]          expected;
   } stim_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [DATA_W-1:0]             req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [DATA_W-1:0]             rsp_tdata;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [fdwm_pkg::CSR_AW-1:0]   csr_paddr;
   logic [fdwm_pkg::CSR_W-1:0]    csr_pwdata;
   logic [fdwm_pkg::CSR_W-1:0]    csr_prdata;
   logic                          csr_pready;

   // model state
   logic signed [SAMPLE_W-1:0]         delay_line [HIST_LEN];
   logic signed [fdwm_pkg::GAIN_W-1:0] even_gain;
   logic signed [fdwm_pkg::GAIN_W-1:0] odd_gain;
   int                                 dry_q15;

   logic [SAMPLE_W-1:0]        expected_out_q [$];
   stim_row_type               directed_rows [$];

   int   sender_idle_pct;
   int   receiver_stall_pct;
   bit   hold_request;
   int   hold_left;
   int   error_count;
   int   sample_count;
   int   write_count;
   int   result_count;
   int   cycle_count;
   logic [SAMPLE_W-1:0] got_sample;

   fir_dry_wet_mixer #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),     // in_sample
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),     // out_sample
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Filter the window, blend with the dry sample, then advance the delay line.
   function automatic logic [SAMPLE_W-1:0] filter_and_shift(input logic signed [SAMPLE_W-1:0] cur);
      longint acc;
      longint tap;
      longint filtered;
      longint mix;
      longint res;
      longint hi;
      longint lo;
      int     j;
      acc = 0;
      hi  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
      lo  = -hi - 1;
      for (j = 0; j < TAPS; j++) begin
         tap = (j < HIST_LEN) ? longint'(delay_line[j]) : longint'(cur);
         acc += tap * ((j % 2 == 0) ? longint'(even_gain) : longint'(odd_gain));
      end
      filtered = (acc + 16384) >>> fdwm_pkg::Q_SHIFT;
      mix = longint'(cur) * dry_q15 + filtered * (32768 - dry_q15);
      res = (mix + 16384) >>> fdwm_pkg::Q_SHIFT;
      if (res > hi) res = hi;
      if (res < lo) res = lo;
      for (j = 0; j + 1 < HIST_LEN; j++)
         delay_line[j] = delay_line[j + 1];
      delay_line[HIST_LEN - 1] = cur;
      return res[SAMPLE_W-1:0];
   endfunction

   task automatic add_sample(input logic [SAMPLE_W-1:0] s, input logic known,
                             input logic [SAMPLE_W-1:0] expected);
      stim_row_type row;
      row = '0;
      row.kind = ROW_SAMPLE;
      row.sample = s;
      row.known = known;
      row.expected = expected;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_write(input fdwm_pkg::reg_index_type idx,
                            input logic [fdwm_pkg::CSR_W-1:0] value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.reg_idx = idx;
      row.wdata = value;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Offer one sample, honoring the sender idle rate; predict at the transfer.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic known,
                              input logic [SAMPLE_W-1:0] expected);
      logic [SAMPLE_W-1:0] predicted;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(s);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = filter_and_shift(s);
      expected_out_q.insert(expected_out_q.size(), known ? expected : predicted);
      sample_count++;
   endtask

   task automatic write_reg(input fdwm_pkg::reg_index_type idx,
                            input logic [fdwm_pkg::CSR_W-1:0] value);
      @(negedge clock);
      req_tvalid  <= 1'b0;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= fdwm_pkg::CSR_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         fdwm_pkg::REG_EVEN_GAIN: even_gain = value[fdwm_pkg::GAIN_W-1:0];
         fdwm_pkg::REG_ODD_GAIN:  odd_gain  = value[fdwm_pkg::GAIN_W-1:0];
         fdwm_pkg::REG_DRY_SHARE:
            dry_q15 = (value[fdwm_pkg::GAIN_W-1:0] > 16'd32768) ? 32768
                                                               : int'(value[fdwm_pkg::GAIN_W-1:0]);
         default: ;
      endcase
      write_count++;
   endtask

   // Let every pending result drain, then give the datapath time to go idle.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(19))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [fdwm_pkg::CSR_W-1:0] with_noise(
      input logic [fdwm_pkg::GAIN_W-1:0] value);
      return {16'($urandom), value};
   endfunction

   // receiver: random stalls plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_sample = rsp_tdata[SAMPLE_W-1:0];
         result_count++;
         if (expected_out_q.size() == 0) begin
            $error("out_sample: no result expected, actual %0d", $signed(got_sample));
            error_count++;
         end else if (got_sample !== expected_out_q[0]) begin
            $error("out_sample: expected %0d, actual %0d",
                   $signed(expected_out_q[0]), $signed(got_sample));
            error_count++;
            void'(expected_out_q.pop_front());
         end else begin
            void'(expected_out_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      int i;
      int p;
      logic [fdwm_pkg::GAIN_W-1:0] dry_word;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      hold_request = 1'b0;
      hold_left    = 0;
      error_count  = 0;
      sample_count = 0;
      write_count  = 0;
      result_count = 0;
      cycle_count  = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      even_gain = fdwm_pkg::EVEN_GAIN_RST;
      odd_gain  = fdwm_pkg::ODD_GAIN_RST;
      dry_q15   = int'(fdwm_pkg::DRY_SHARE_RST);
      for (i = 0; i < HIST_LEN; i++) delay_line[i] = '0;

      // reset state: silence in gives silence out
      add_sample(16'h0000, 1'b1, 16'h0000);
      add_sample(16'h7FFF, 1'b0, '0);
      add_sample(16'h8000, 1'b0, '0);
      add_sample(16'h0001, 1'b0, '0);
      add_sample(16'hFFFF, 1'b0, '0);
      // index past the register file is dropped
      add_write(fdwm_pkg::REG_UNUSED, 32'hFFFF_FFFF);
      // share above one clamps to dry only: output equals input
      add_write(fdwm_pkg::REG_DRY_SHARE, 32'h0000_FFFF);
      add_sample(16'h7FFF, 1'b1, 16'h7FFF);
      add_sample(16'h8000, 1'b1, 16'h8000);
      add_sample(16'h5555, 1'b1, 16'h5555);
      add_sample(16'hAAAA, 1'b1, 16'hAAAA);
      // wet only with near-unity taps: a window dominated by one extreme saturates
      add_write(fdwm_pkg::REG_EVEN_GAIN, 32'h0000_7FFF);
      add_write(fdwm_pkg::REG_ODD_GAIN, 32'h0000_7FFF);
      add_write(fdwm_pkg::REG_DRY_SHARE, 32'h0000_0000);
      for (i = 0; i < 6; i++) add_sample(16'h8000, (i == 5), 16'h8000);
      for (i = 0; i < 6; i++) add_sample(16'h7FFF, (i == 5), 16'h7FFF);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_drained();
            write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
         end else begin
            send_sample(directed_rows[i].sample, directed_rows[i].known,
                        directed_rows[i].expected);
         end
      end

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin
               write_reg(fdwm_pkg::REG_EVEN_GAIN, with_noise(16'($urandom)));
               write_reg(fdwm_pkg::REG_ODD_GAIN, with_noise(16'($urandom)));
               write_reg(fdwm_pkg::REG_DRY_SHARE, with_noise(16'($urandom_range(32768))));
            end
            1: begin
               write_reg(fdwm_pkg::REG_EVEN_GAIN, 32'h0000_8000);
               write_reg(fdwm_pkg::REG_ODD_GAIN, 32'h0000_7FFF);
               write_reg(fdwm_pkg::REG_DRY_SHARE, 32'h0000_0000);
            end
            2: begin
               write_reg(fdwm_pkg::REG_EVEN_GAIN, 32'h0000_7FFF);
               write_reg(fdwm_pkg::REG_ODD_GAIN, 32'h0000_8000);
               write_reg(fdwm_pkg::REG_DRY_SHARE, 32'h0000_8000);
            end
            3: begin
               write_reg(fdwm_pkg::REG_EVEN_GAIN, with_noise(16'($urandom)));
               write_reg(fdwm_pkg::REG_ODD_GAIN, with_noise(16'($urandom)));
               dry_word = 16'($urandom_range(65535, 32769));
               write_reg(fdwm_pkg::REG_DRY_SHARE, with_noise(dry_word));
            end
            default: begin
               write_reg(fdwm_pkg::REG_EVEN_GAIN, with_noise(16'($urandom_range(4095))));
               write_reg(fdwm_pkg::REG_ODD_GAIN, with_noise(16'($urandom)));
               write_reg(fdwm_pkg::REG_DRY_SHARE, 32'h0000_0001);
            end
         endcase
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         // back up the output while samples keep coming
         if (p == 0) hold_request = 1'b1;
         for (i = 0; i < PHASE_ITEMS; i++)
            send_sample(random_sample(), 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (expected_out_q.size() != 0) begin
         $error("out_sample: %0d results never arrived", expected_out_q.size());
         error_count++;
      end

      $display("run covered %0d samples, %0d results and %0d register writes",
               sample_count, result_count, write_count);
      $display("gain and share extremes, clamp, ignored index, %0d idle phases", PHASES);
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
